// ===== design/clbw_pkg.sv =====
// clbw_pkg: shared constants, types and the microprogram of the character-lcd bus writer
// depends on nothing; used by clbw_seq, clbw_dp, char_lcd_bus_writer and the bench
`timescale 1ns / 1ps
`default_nettype none

package clbw_pkg;

    // number handling
    localparam int VALUE_WIDTH = 16;
    localparam int NUM_DIGITS  = 5;
    localparam int NUM_W       = VALUE_WIDTH + 1;
    localparam int POW_W       = 3;
    localparam int DIG_W       = 4;
    localparam logic [POW_W-1:0] LAST_DIGIT = POW_W'(NUM_DIGITS - 1);

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] SET_ADDR_BIT = 8'h80;

    // request codes
    localparam logic [1:0] OP_CMD    = 2'd0;
    localparam logic [1:0] OP_DATA   = 2'd1;
    localparam logic [1:0] OP_CURSOR = 2'd2;
    localparam logic [1:0] OP_NUMBER = 2'd3;

    // bus write kinds
    localparam logic [1:0] OUT_NONE = 2'd0;
    localparam logic [1:0] OUT_HI   = 2'd1;
    localparam logic [1:0] OUT_LO   = 2'd2;

    // branch conditions
    localparam logic [2:0] C_NEXT     = 3'd0;
    localparam logic [2:0] C_JUMP     = 3'd1;
    localparam logic [2:0] C_DISPATCH = 3'd2;
    localparam logic [2:0] C_MODE8    = 3'd3;
    localparam logic [2:0] C_FIN      = 3'd4;
    localparam logic [2:0] C_SKIP     = 3'd5;

    // program steps
    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] PC_WAIT  = 3'd0;
    localparam logic [PC_W-1:0] PC_MODE  = 3'd1;
    localparam logic [PC_W-1:0] PC_HI    = 3'd2;
    localparam logic [PC_W-1:0] PC_LO    = 3'd3;
    localparam logic [PC_W-1:0] PC_DIGIT = 3'd4;
    localparam logic [PC_W-1:0] PC_DMODE = 3'd5;
    localparam logic [PC_W-1:0] PC_DHI   = 3'd6;

    typedef struct packed {
        logic            load;
        logic            digit;
        logic [1:0]      out_kind;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } ctl_t;

    typedef struct packed {
        logic start;
        logic is_num;
        logic mode8;
        logic fin;
        logic skip;
    } stat_t;

    // microprogram rom
    function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
        ctl_t w;
        begin
            w = '0;
            unique case (pc)
                PC_WAIT:
                begin
                    w.load   = 1'b1;
                    w.cond   = C_DISPATCH;
                    w.target = PC_DIGIT;
                end
                PC_MODE:
                begin
                    w.cond   = C_MODE8;
                    w.target = PC_LO;
                end
                PC_HI:
                begin
                    w.out_kind = OUT_HI;
                    w.cond     = C_NEXT;
                end
                PC_LO:
                begin
                    w.out_kind = OUT_LO;
                    w.cond     = C_FIN;
                    w.target   = PC_WAIT;
                end
                PC_DIGIT:
                begin
                    w.digit  = 1'b1;
                    w.cond   = C_SKIP;
                    w.target = PC_DIGIT;
                end
                PC_DMODE:
                begin
                    w.cond   = C_MODE8;
                    w.target = PC_LO;
                end
                PC_DHI:
                begin
                    w.out_kind = OUT_HI;
                    w.cond     = C_JUMP;
                    w.target   = PC_LO;
                end
                default:
                begin
                    w.cond   = C_JUMP;
                    w.target = PC_WAIT;
                end
            endcase
            return w;
        end
    endfunction

    // decimal weight of each digit place, most significant first
    function automatic logic [NUM_W-1:0] pow10(input logic [POW_W-1:0] idx);
        logic [NUM_W-1:0] p;
        begin
            unique case (idx)
                3'd0:    p = NUM_W'(10000);
                3'd1:    p = NUM_W'(1000);
                3'd2:    p = NUM_W'(100);
                3'd3:    p = NUM_W'(10);
                default: p = NUM_W'(1);
            endcase
            return p;
        end
    endfunction

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] b;
        begin
            unique case (row)
                2'd0:    b = 8'h00;
                2'd1:    b = 8'h40;
                2'd2:    b = 8'h14;
                default: b = 8'h54;
            endcase
            return b;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/clbw_seq.sv =====
// clbw_seq: step counter and branch logic that walks the microprogram
// depends on clbw_pkg
`timescale 1ns / 1ps
`default_nettype none

module clbw_seq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  clbw_pkg::stat_t    stat,
    output clbw_pkg::ctl_t     ctl,
    output logic               busy
);
    import clbw_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic [PC_W-1:0] pc_inc;

    always_comb
    begin
        ctl    = ucode(pc_reg);
        pc_inc = pc_reg + PC_W'(1);
        unique case (ctl.cond)
            C_NEXT:     pc_next = pc_inc;
            C_JUMP:     pc_next = ctl.target;
            C_DISPATCH: pc_next = !stat.start ? pc_reg : (stat.is_num ? ctl.target : pc_inc);
            C_MODE8:    pc_next = stat.mode8 ? ctl.target : pc_inc;
            C_FIN:      pc_next = stat.fin ? ctl.target : pc_inc;
            C_SKIP:     pc_next = stat.skip ? ctl.target : pc_inc;
            default:    pc_next = PC_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= PC_WAIT;
        else
            pc_reg <= pc_next;
    end

    assign busy = (pc_reg != PC_WAIT);

endmodule

`default_nettype wire

// ===== design/clbw_dp.sv =====
// clbw_dp: datapath with byte register, digit extractor and registered bus output
// depends on clbw_pkg
`timescale 1ns / 1ps
`default_nettype none

module clbw_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  clbw_pkg::ctl_t                          ctl,
    input  wire logic                               start,
    input  wire logic [1:0]                         op,
    input  wire logic [15:0]                        value,
    input  wire logic [1:0]                         row,
    input  wire logic [5:0]                         col,
    input  wire logic                               cfg_write,
    input  wire logic                               cfg_data,
    output clbw_pkg::stat_t                         stat,
    output logic                                    strobe,
    output logic                                    reg_select,
    output logic [7:0]                              bus_value,
    output logic                                    last,
    output logic                                    mode
);
    import clbw_pkg::*;

    logic                   mode_reg;
    logic [7:0]             byte_reg;
    logic                   rs_reg;
    logic [VALUE_WIDTH-1:0] num_reg;
    logic [POW_W-1:0]       pow_reg;
    logic                   fin_reg;
    logic                   started_reg;
    logic                   strobe_reg;
    logic                   rs_out_reg;
    logic [7:0]             bus_reg;
    logic                   last_reg;

    logic [NUM_W-1:0]       weight;
    logic [NUM_W-1:0]       num_ext;
    logic [NUM_W-1:0]       mult;
    logic [NUM_W-1:0]       sub;
    logic [DIG_W-1:0]       dig;
    logic [7:0]             load_byte;
    logic                   load_rs;

    // digit = largest k with k * weight <= num
    always_comb
    begin
        weight  = pow10(pow_reg);
        num_ext = {1'b0, num_reg};
        dig     = '0;
        sub     = '0;
        mult    = '0;
        for (int k = 1; k <= 9; k++)
        begin
            mult = weight * NUM_W'(k);
            if (num_ext >= mult)
            begin
                dig = DIG_W'(k);
                sub = mult;
            end
        end
    end

    always_comb
    begin
        load_rs = 1'b0;
        case (op) inside
            OP_CMD:
            begin
                load_byte = value[7:0];
                load_rs   = 1'b0;
            end
            OP_CURSOR:
            begin
                load_byte = (row_base(row) + {2'b00, col}) | SET_ADDR_BIT;
                load_rs   = 1'b0;
            end
            OP_DATA, OP_NUMBER:
            begin
                load_byte = value[7:0];
                load_rs   = 1'b1;
            end
            default:
            begin
                load_byte = value[7:0];
                load_rs   = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        stat.start  = start;
        stat.is_num = (op == OP_NUMBER);
        stat.mode8  = !mode_reg;
        stat.fin    = fin_reg;
        stat.skip   = (dig == '0) && !started_reg && (pow_reg != LAST_DIGIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b1;
        else if (cfg_write)
            mode_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && start)
        begin
            byte_reg    <= load_byte;
            rs_reg      <= load_rs;
            num_reg     <= value[VALUE_WIDTH-1:0];
            pow_reg     <= '0;
            fin_reg     <= (op != OP_NUMBER);
            started_reg <= 1'b0;
        end
        else if (ctl.digit)
        begin
            byte_reg    <= CHAR_ZERO + {4'b0000, dig};
            num_reg     <= num_reg - sub[VALUE_WIDTH-1:0];
            pow_reg     <= pow_reg + POW_W'(1);
            fin_reg     <= (pow_reg == LAST_DIGIT);
            started_reg <= started_reg || (dig != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= (ctl.out_kind != OUT_NONE);
    end

    always_ff @(posedge clk)
    begin
        rs_out_reg <= rs_reg;
        if (ctl.out_kind == OUT_HI)
        begin
            bus_reg  <= {4'b0000, byte_reg[7:4]};
            last_reg <= 1'b0;
        end
        else
        begin
            bus_reg  <= mode_reg ? {4'b0000, byte_reg[3:0]} : byte_reg;
            last_reg <= fin_reg;
        end
    end

    assign strobe     = strobe_reg;
    assign reg_select = rs_out_reg;
    assign bus_value  = bus_reg;
    assign last       = last_reg;
    assign mode       = mode_reg;

endmodule

`default_nettype wire

// ===== design/char_lcd_bus_writer.sv =====
// a byte request is taken in wait and goes through mode, then hi and lo in four-bit mode,
//   or lo alone with the whole byte in eight-bit mode
// a number goes from wait to the digit loop: each place takes a digit step, leading-zero places
//   loop there, and each printed digit goes through dmode, then dhi (four-bit only) and lo
// the microprogram walks one step a cycle; a new request is taken only back in wait
// reset: step counter to wait, no word pending, bus mode to four-bit; results cannot be stalled
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_bus_writer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request side
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  op,
    input  wire logic [15:0] value,
    input  wire logic [1:0]  row,
    input  wire logic [5:0]  col,
    // bus mode register
    input  wire logic        cfg_write,
    input  wire logic        cfg_data,
    // bus word side
    output logic             strobe,
    output logic             reg_select,
    output logic [7:0]       bus_value,
    output logic             last
);
    import clbw_pkg::*;

    // control word from the rom and status flags back from the datapath
    ctl_t  ctl;
    stat_t stat;
    logic  mode;

    // sequencer: step counter plus conditional branches over the microprogram
    //   wait   : take the request, branch to the digit loop for numbers
    //   mode   : skip the high nibble in eight-bit mode
    //   hi/lo  : emit the nibbles (or the full byte), leave when the final word went out
    //   digit  : peel one decimal place, loop back while still in leading zeros
    clbw_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    // datapath: byte register, place-value digit extractor, registered word output
    clbw_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .start      (start),
        .op         (op),
        .value      (value),
        .row        (row),
        .col        (col),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .stat       (stat),
        .strobe     (strobe),
        .reg_select (reg_select),
        .bus_value  (bus_value),
        .last       (last),
        .mode       (mode)
    );

    // final word of a request leaves the block idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> !busy)
        else $error("final word seen while still busy");

    // a word that is not the final one always has more to follow
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("non-final word with the sequencer idle");

    // a taken request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request taken but sequencer stayed idle");

    // four-bit words carry nothing in the high nibble
    a_nibble_clean: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && mode |-> bus_value[7:4] == 4'h0)
        else $error("high nibble set on a four-bit word");

endmodule

`default_nettype wire

// ===== test/char_lcd_bus_writer_tb.sv =====
// char_lcd_bus_writer_tb: self-checking bench for the character-lcd bus writer
// drives requests and bus mode writes, predicts every bus word, checks them in order
// depends on clbw_pkg (request codes, set-address bit, ascii zero) and the block itself
`timescale 1ns / 1ps

module char_lcd_bus_writer_tb;

    import clbw_pkg::*;

    // bus mode values
    localparam logic MODE_8BIT = 1'b0;
    localparam logic MODE_4BIT = 1'b1;

    // register select values
    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    // cycles left after the last word before a mode write, and at the end
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES   = 24;
    // cycles with no word, request or mode write before the run is abandoned
    localparam int STALL_LIMIT   = 2000;

    // ddram start address of each display row
    localparam logic [7:0] ROW_START [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    // one pending item for the driver: a request, or a bus mode write
    typedef struct {
        bit          is_mode;
        logic        mode;
        logic [1:0]  op;
        logic [15:0] value;
        logic [1:0]  row;
        logic [5:0]  col;
        int          gap;
    } lcd_req_t;

    // one expected bus word
    typedef struct packed {
        logic       reg_select;
        logic [7:0] bus_value;
        logic       last;
    } bus_word_t;

    typedef enum logic [2:0] {
        D_IDLE,
        D_GAP,
        D_OFFER,
        D_DRAIN,
        D_SETTLE,
        D_CFG
    } drv_state_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  op = OP_CMD;
    logic [15:0] value = '0;
    logic [1:0]  row = '0;
    logic [5:0]  col = '0;
    logic        cfg_write = 1'b0;
    logic        cfg_data = 1'b0;
    logic        strobe;
    logic        reg_select;
    logic [7:0]  bus_value;
    logic        last;

    lcd_req_t    pending_reqs[$];
    bus_word_t   expected_words[$];
    lcd_req_t    cur_req;
    drv_state_t  drv_state = D_IDLE;
    int          gap_cnt = 0;
    int          settle_cnt = 0;
    int          quiet_cycles = 0;
    int          fail_count = 0;
    // predicted bus mode, four-bit out of reset
    logic        pred_mode = MODE_4BIT;
    // when set, new requests are queued with no gap before them
    bit          no_gaps = 1'b0;

    char_lcd_bus_writer DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .value      (value),
        .row        (row),
        .col        (col),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .strobe     (strobe),
        .reg_select (reg_select),
        .bus_value  (bus_value),
        .last       (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // one byte becomes one word in eight-bit mode, high then low nibble in four-bit mode
    task automatic queue_byte(input logic rs, input logic [7:0] b, input logic fin);
        if (pred_mode == MODE_4BIT)
        begin
            expected_words.push_back('{rs, {4'h0, b[7:4]}, 1'b0});
            expected_words.push_back('{rs, {4'h0, b[3:0]}, fin});
        end
        else
        begin
            expected_words.push_back('{rs, b, fin});
        end
    endtask

    task automatic predict_words(input lcd_req_t r);
        logic [7:0]  digits [5];
        int          cnt;
        int          k;
        int unsigned num;
        logic [7:0]  addr;
        cnt = 0;
        case (r.op)
            OP_CMD:
            begin
                queue_byte(RS_INSTR, r.value[7:0], 1'b1);
            end
            OP_DATA:
            begin
                queue_byte(RS_DATA, r.value[7:0], 1'b1);
            end
            OP_CURSOR:
            begin
                // column is added as it is, even past the visible width
                addr = ROW_START[r.row] + {2'b00, r.col};
                queue_byte(RS_INSTR, addr | SET_ADDR_BIT, 1'b1);
            end
            default:
            begin
                // decimal digits, least significant found first; zero gives one digit
                num = r.value;
                if (num == 0)
                begin
                    digits[0] = CHAR_ZERO;
                    cnt = 1;
                end
                while (num > 0)
                begin
                    digits[cnt] = CHAR_ZERO + 8'(num % 10);
                    num = num / 10;
                    cnt++;
                end
                for (k = cnt - 1; k >= 0; k--)
                    queue_byte(RS_DATA, digits[k], k == 0);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------

    // take the next pending item and set start for the coming cycle, once per step
    task automatic fetch_next;
        if (pending_reqs.size() == 0)
        begin
            start <= 1'b0;
            drv_state <= D_IDLE;
        end
        else
        begin
            cur_req = pending_reqs.pop_front();
            if (cur_req.is_mode)
            begin
                start <= 1'b0;
                drv_state <= D_DRAIN;
            end
            else if (cur_req.gap == 0)
            begin
                start <= 1'b1;
                op    <= cur_req.op;
                value <= cur_req.value;
                row   <= cur_req.row;
                col   <= cur_req.col;
                drv_state <= D_OFFER;
            end
            else
            begin
                start <= 1'b0;
                gap_cnt <= cur_req.gap;
                drv_state <= D_GAP;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            case (drv_state)
                D_IDLE:
                begin
                    fetch_next();
                end
                D_GAP:
                begin
                    if (gap_cnt <= 1)
                    begin
                        start <= 1'b1;
                        op    <= cur_req.op;
                        value <= cur_req.value;
                        row   <= cur_req.row;
                        col   <= cur_req.col;
                        drv_state <= D_OFFER;
                    end
                    else
                    begin
                        gap_cnt <= gap_cnt - 1;
                    end
                end
                D_OFFER:
                begin
                    // start is high here, so a low busy means the request was taken at this edge
                    if (!busy)
                    begin
                        predict_words(cur_req);
                        fetch_next();
                    end
                end
                D_DRAIN:
                begin
                    // mode writes only once every word of earlier requests is out
                    if (expected_words.size() == 0 && !busy)
                    begin
                        settle_cnt <= SETTLE_CYCLES;
                        drv_state <= D_SETTLE;
                    end
                end
                D_SETTLE:
                begin
                    if (settle_cnt <= 1)
                    begin
                        cfg_write <= 1'b1;
                        cfg_data  <= cur_req.mode;
                        drv_state <= D_CFG;
                    end
                    else
                    begin
                        settle_cnt <= settle_cnt - 1;
                    end
                end
                default:
                begin
                    // cfg_write was high across this edge, so the register now holds the mode
                    pred_mode = cur_req.mode;
                    cfg_write <= 1'b0;
                    fetch_next();
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // monitor: every strobed word is checked against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        bus_word_t want;
        if (rst_n && strobe)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: reg_select %0d bus_value %02h last %0d",
                       reg_select, bus_value, last);
                fail_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (reg_select !== want.reg_select)
                begin
                    $error("reg_select: expected %0d, actual %0d", want.reg_select, reg_select);
                    fail_count++;
                end
                if (bus_value !== want.bus_value)
                begin
                    $error("bus_value: expected %02h, actual %02h", want.bus_value, bus_value);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, last);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles where nothing at all is handed over
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe || cfg_write)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic add_req(input logic [1:0] o, input logic [15:0] v,
                           input logic [1:0] r, input logic [5:0] c);
        lcd_req_t q;
        q.is_mode = 1'b0;
        q.mode    = MODE_4BIT;
        q.op      = o;
        q.value   = v;
        q.row     = r;
        q.col     = c;
        q.gap     = no_gaps ? 0 : $urandom_range(0, 17);
        pending_reqs.push_back(q);
    endtask

    // a mode write also holds the sender off until every word has come
    task automatic add_mode(input logic m);
        lcd_req_t q;
        q.is_mode = 1'b1;
        q.mode    = m;
        q.op      = OP_CMD;
        q.value   = '0;
        q.row     = '0;
        q.col     = '0;
        q.gap     = 0;
        pending_reqs.push_back(q);
    endtask

    // numbers of every digit count, not just mostly five-digit ones
    function automatic logic [15:0] pick_number();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 9));
            1:       return 16'($urandom_range(10, 99));
            2:       return 16'($urandom_range(100, 999));
            3:       return 16'($urandom_range(1000, 9999));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_random(input int n);
        int          i;
        logic [1:0]  o;
        for (i = 0; i < n; i++)
        begin
            // every third run of eight goes back to back
            no_gaps = ((i / 8) % 3) == 2;
            o = 2'($urandom_range(0, 3));
            add_req(o, (o == OP_NUMBER) ? pick_number() : 16'($urandom),
                    2'($urandom), 6'($urandom));
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        // directed, four-bit
        add_mode(MODE_4BIT);
        add_req(OP_CMD,    16'h0000, 2'd0, 6'd0);
        add_req(OP_CMD,    16'hABFF, 2'd3, 6'd63);
        add_req(OP_DATA,   16'h00FF, 2'd0, 6'd0);
        add_req(OP_DATA,   16'hFF00, 2'd2, 6'd21);
        add_req(OP_CURSOR, 16'hFFFF, 2'd0, 6'd0);
        add_req(OP_CURSOR, 16'h0000, 2'd3, 6'd39);
        // column past the visible width
        add_req(OP_CURSOR, 16'h0000, 2'd1, 6'd63);
        add_req(OP_CURSOR, 16'h0000, 2'd2, 6'd20);
        // zero gives a single digit
        add_req(OP_NUMBER, 16'd0,     2'd3, 6'd63);
        add_req(OP_NUMBER, 16'd65535, 2'd0, 6'd0);
        add_req(OP_NUMBER, 16'd10000, 2'd0, 6'd0);
        add_req(OP_NUMBER, 16'd10,    2'd0, 6'd0);
        add_req(OP_NUMBER, 16'd9,     2'd0, 6'd0);
        // directed, eight-bit
        add_mode(MODE_8BIT);
        add_req(OP_CMD,    16'h125A, 2'd0, 6'd0);
        add_req(OP_DATA,   16'h80A5, 2'd1, 6'd1);
        add_req(OP_CURSOR, 16'h0000, 2'd3, 6'd63);
        add_req(OP_CURSOR, 16'h0000, 2'd0, 6'd0);
        add_req(OP_NUMBER, 16'd0,     2'd0, 6'd0);
        add_req(OP_NUMBER, 16'd65535, 2'd0, 6'd0);
        add_req(OP_NUMBER, 16'd12345, 2'd0, 6'd0);
        add_req(OP_NUMBER, 16'd1,     2'd0, 6'd0);
        // random phases through both modes, one mode write leaving the mode as it is
        add_mode(MODE_4BIT);
        add_random(22);
        add_mode(MODE_8BIT);
        add_random(22);
        add_mode(MODE_8BIT);
        add_random(22);
        add_mode(MODE_4BIT);
        add_random(23);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // everything taken and every word seen, then a tail for stray words
        while (pending_reqs.size() != 0 || drv_state != D_IDLE || expected_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
